>>> hw/rtl/sval7_pkg.sv
// Shared constants, segment codes and the digit-to-segment decoder.
`timescale 1ns / 1ps
`default_nettype none
package sval7_pkg;

  localparam int CFG_W     = 4;
  localparam int POS_W     = 3;
  localparam int SEG_W     = 8;
  localparam int CFG_RESET = 4;

  localparam logic [SEG_W-1:0] SEG_MINUS = 8'h40;
  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

  // bit0 = a ... bit6 = g, point never lit
  function automatic logic [SEG_W-1:0] seg_of_digit(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0: s = 8'h3f;
      4'd1: s = 8'h06;
      4'd2: s = 8'h5b;
      4'd3: s = 8'h4f;
      4'd4: s = 8'h66;
      4'd5: s = 8'h6d;
      4'd6: s = 8'h7d;
      4'd7: s = 8'h07;
      4'd8: s = 8'h7f;
      4'd9: s = 8'h6f;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/sval7_if.sv
// Valid/ready channel interfaces for the value input and the position output.
`timescale 1ns / 1ps
`default_nettype none
interface sval7_in_if #(parameter int VALUE_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sval7_out_if;
  logic                             valid;
  logic                             ready;
  logic [sval7_pkg::POS_W-1:0]      position;
  logic [sval7_pkg::SEG_W-1:0]      segments;
  logic                             overflow;
  logic                             last;

  modport source (output valid, output position, output segments, output overflow,
                  output last, input ready);
  modport sink   (input valid, input position, input segments, input overflow,
                  input last, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/sval7_bcd.sv
// Bit-serial binary to BCD converter (shift and add-3, one bit per cycle).
`timescale 1ns / 1ps
`default_nettype none
module sval7_bcd #(
  parameter int VALUE_BITS = 16,
  parameter int DIGITS     = 5
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [VALUE_BITS-1:0]       mag,
  output logic                             done,
  output logic [DIGITS-1:0][3:0]           bcd
);

  localparam int KW = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0]   sh;
  logic [KW-1:0]           cnt;
  logic                    busy;
  logic [DIGITS-1:0][3:0]  adj;

  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      adj[d] = (bcd[d] >= 4'd5) ? bcd[d] + 4'd3 : bcd[d];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= KW'(VALUE_BITS);
      end else if (busy) begin
        cnt <= cnt - KW'(1);
        if (cnt == KW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= mag;
      bcd <= '0;
    end else if (busy) begin
      {bcd, sh} <= {adj, sh} << 1;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/signed_value_to_seven_segment.sv
// Top level: signed value to a left-justified seven-segment decimal field.
// An accepted item is converted to BCD and its positions are then emitted,
//   one position per cycle while the sink takes them.
// A new item is taken only after every position of the last one has been
//   emitted; the bit-serial BCD converter takes one bit per cycle.
// Reset (rst, synchronous): idle, no result pending, field width 4.
`timescale 1ns / 1ps
`default_nettype none
module signed_value_to_seven_segment #(
  parameter int MAX_POSITIONS = 8,
  parameter int VALUE_BITS    = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [sval7_pkg::CFG_W-1:0]  cfg_wdata,
  sval7_in_if.sink                          din,
  sval7_out_if.source                       dout
);

  // Enough decimal digits for 2^VALUE_BITS (log10(2) ~ 0.30103).
  localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  // Counter width covering field width, digit count and sign.
  localparam int CW     = $clog2(MAX_POSITIONS + DIGITS + 2);
  localparam int IW     = $clog2(DIGITS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t                          state;
  logic [sval7_pkg::CFG_W-1:0]     field_positions;
  logic [CW-1:0]                   width;
  logic [CW-1:0]                   pos;
  logic [CW-1:0]                   digit_count;
  logic [CW-1:0]                   needed;
  logic                            ovf;
  logic                            neg;

  logic                            accept;
  logic [VALUE_BITS-1:0]           mag;
  logic                            conv_done;
  logic [DIGITS-1:0][3:0]          bcd;

  logic [CW-1:0]                   n_comb;
  logic [CW-1:0]                   needed_comb;
  logic [CW-1:0]                   k;
  logic [CW-1:0]                   idx;
  logic [sval7_pkg::SEG_W-1:0]     seg;
  logic                            load;

  // Out register: an item can be taken while the last result still waits.
  logic                            out_valid;
  logic [sval7_pkg::POS_W-1:0]     out_pos;
  logic [sval7_pkg::SEG_W-1:0]     out_seg;
  logic                            out_ovf;
  logic                            out_last;

  assign din.ready     = (state == S_IDLE);
  assign accept        = din.valid && din.ready;
  assign dout.valid    = out_valid;
  assign dout.position = out_pos;
  assign dout.segments = out_seg;
  assign dout.overflow = out_ovf;
  assign dout.last     = out_last;

  // Two's complement magnitude; the most negative value maps to 2^(N-1).
  assign mag = din.value[VALUE_BITS-1] ? (~din.value + VALUE_BITS'(1)) : din.value;

  sval7_bcd #(
    .VALUE_BITS (VALUE_BITS),
    .DIGITS     (DIGITS)
  ) u_bcd (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .mag   (mag),
    .done  (conv_done),
    .bcd   (bcd)
  );

  // Effective field width: 0 acts as 1, clipped to MAX_POSITIONS.
  always_comb begin
    if (field_positions == '0) begin
      width = CW'(1);
    end else if (32'(field_positions) > MAX_POSITIONS) begin
      width = CW'(MAX_POSITIONS);
    end else begin
      width = CW'(field_positions);
    end
  end

  // Digit count: highest nonzero BCD digit, at least one digit for zero.
  always_comb begin
    n_comb = CW'(1);
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd[d] != 4'd0) begin
        n_comb = CW'(d + 1);
      end
    end
    needed_comb = n_comb + CW'(neg);
  end

  // Pattern for the current position; digits fill left-justified after sign.
  always_comb begin
    k   = pos - CW'(neg);
    idx = digit_count - CW'(1) - k;
    if (ovf || pos >= needed) begin
      seg = sval7_pkg::SEG_BLANK;
    end else if (neg && pos == '0) begin
      seg = sval7_pkg::SEG_MINUS;
    end else begin
      seg = sval7_pkg::seg_of_digit(bcd[idx[IW-1:0]]);
    end
  end

  assign load = (state == S_EMIT) && (!out_valid || dout.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      field_positions <= sval7_pkg::CFG_W'(sval7_pkg::CFG_RESET);
    end else if (cfg_we) begin
      field_positions <= cfg_wdata;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pos       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CONV;
          end
        end
        S_CONV: begin
          if (conv_done) begin
            state <= S_EMIT;
            pos   <= '0;
          end
        end
        S_EMIT: begin
          if (load) begin
            pos <= pos + CW'(1);
            if (pos + CW'(1) == width) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= din.value[VALUE_BITS-1];
    end
    if (state == S_CONV && conv_done) begin
      digit_count <= n_comb;
      needed      <= needed_comb;
      ovf         <= needed_comb > width;
    end
    if (load) begin
      out_pos  <= pos[sval7_pkg::POS_W-1:0];
      out_seg  <= seg;
      out_ovf  <= ovf;
      out_last <= (pos + CW'(1) == width);
    end
  end

`ifndef SYNTHESIS
  a_ovf_blank: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ovf |-> out_seg == sval7_pkg::SEG_BLANK)
    else $error("overflow result with lit segments");

  a_done_in_conv: assert property (@(posedge clk) disable iff (rst)
    conv_done |-> state == S_CONV)
    else $error("converter finished outside conversion");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> digit_count != '0 && pos < width)
    else $error("bad digit count or position during emit");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    load && (pos + CW'(1) == width) |=> state == S_IDLE && out_last)
    else $error("last position did not end the item");
`endif

endmodule
`default_nettype wire

>>> sim/signed_value_to_seven_segment_tb.sv
// Self-checking bench: signed values in, per-position seven-segment results checked.
`timescale 1ns / 1ps
module signed_value_to_seven_segment_tb;

  localparam int MAX_POS      = 8;
  localparam int VAL_W        = 16;
  localparam int IDLE_LIMIT   = 3000;  // cycles without any item moving
  localparam int TAIL_CYCLES  = 40;    // watch for strays after the last result
  localparam int PHASE_ITEMS  = 50;
  localparam int PRESSURE_AT  = 25;

  // glyphs for 0..9, bit0 = a ... bit6 = g
  localparam logic [sval7_pkg::SEG_W-1:0] DIGIT_GLYPH [0:9] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
  };
  localparam int TEN_POW [0:4] = '{1, 10, 100, 1000, 10000};

  typedef struct packed {
    logic [sval7_pkg::POS_W-1:0] position;
    logic [sval7_pkg::SEG_W-1:0] segments;
    logic                        overflow;
    logic                        last;
  } seg_result_t;

  // Holds the field width and the queue of positions still to arrive.
  class field_scoreboard;
    seg_result_t                 glyph_q[$];
    logic [sval7_pkg::CFG_W-1:0] field_reg;
    int unsigned                 mismatches;

    function new();
      field_reg  = sval7_pkg::CFG_W'(sval7_pkg::CFG_RESET);
      mismatches = 0;
    endfunction

    function void set_field(input logic [sval7_pkg::CFG_W-1:0] w);
      field_reg = w;
    endfunction

    function int pending();
      return glyph_q.size();
    endfunction

    // Build the whole field for one accepted value.
    function void note_value(input logic [VAL_W-1:0] v);
      logic        neg;
      logic [3:0]  digs [0:5];
      int unsigned mag, n_digits, needed, width, k, i;
      logic        too_wide;
      seg_result_t r;
      width = (field_reg == 0) ? 1 : ((field_reg > MAX_POS) ? MAX_POS : field_reg);
      neg = v[VAL_W-1];
      mag = neg ? (32'd65536 - v) : v;
      n_digits = 0;
      do begin
        digs[n_digits] = mag % 10;
        mag = mag / 10;
        n_digits++;
      end while (mag != 0);
      needed   = n_digits + (neg ? 1 : 0);
      too_wide = needed > width;
      for (i = 0; i < width; i++) begin
        r.segments = sval7_pkg::SEG_BLANK;
        if (!too_wide && i < needed) begin
          if (neg && i == 0) begin
            r.segments = sval7_pkg::SEG_MINUS;
          end else begin
            k = i - (neg ? 1 : 0);
            r.segments = DIGIT_GLYPH[digs[n_digits - 1 - k]];
          end
        end
        r.position = i[sval7_pkg::POS_W-1:0];
        r.overflow = too_wide;
        r.last     = (i == width - 1);
        glyph_q.push_back(r);
      end
    endfunction

    function void log_miss(input string why, input seg_result_t want,
                           input seg_result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display({"[%0t] %s: want pos %0d seg %02h ovf %b last %b,",
                  " got pos %0d seg %02h ovf %b last %b"},
                 $time, why, want.position, want.segments, want.overflow, want.last,
                 got.position, got.segments, got.overflow, got.last);
    endfunction

    function void check_position(input seg_result_t got);
      seg_result_t want;
      if (glyph_q.size() == 0) begin
        want = '0;
        log_miss("result with nothing pending", want, got);
      end else begin
        want = glyph_q.pop_front();
        if (got.position !== want.position || got.segments !== want.segments ||
            got.overflow !== want.overflow || got.last !== want.last)
          log_miss("field mismatch", want, got);
      end
    endfunction

    // Anything still queued at the end never showed up.
    function void close_out();
      if (glyph_q.size() != 0) begin
        $display("%0d expected results never arrived", glyph_q.size());
        mismatches += glyph_q.size();
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_we = 1'b0;
  logic [sval7_pkg::CFG_W-1:0] cfg_wdata = '0;
  bit                          pace_on;     // random idling on both sides when set
  int unsigned                 idle_cycles;
  field_scoreboard             sb;

  sval7_in_if #(.VALUE_BITS(VAL_W)) din_if ();
  sval7_out_if                       dout_if ();

  signed_value_to_seven_segment #(
    .MAX_POSITIONS(MAX_POS),
    .VALUE_BITS   (VAL_W)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .din      (din_if),
    .dout     (dout_if)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: any item moving on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Mix of value shapes: full random, scaled magnitudes that fit narrow
  // fields, decade boundaries, and single digits.
  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned mag, p;
    logic        neg;
    logic [VAL_W-1:0] v;
    neg = $urandom_range(0, 1);
    case ($urandom_range(0, 3))
      0: begin
        mag = $urandom;
        neg = 1'b0;
      end
      1: begin
        p   = TEN_POW[$urandom_range(0, 4)];
        mag = $urandom_range(0, p * 10 - 1);
      end
      2: begin
        p   = TEN_POW[$urandom_range(0, 4)] * 10;
        mag = (p > 32768) ? $urandom_range(32766, 32768) : p - 1 + $urandom_range(0, 1);
      end
      default: mag = $urandom_range(0, 9);
    endcase
    if (!neg && mag > 32767 && mag <= 32768) mag = 32767;
    v = mag[VAL_W-1:0];
    if (neg) v = -v;
    return v;
  endfunction

  // Present one value after an optional gap and hold until it is taken.
  // valid is left high so back-to-back items never toggle it within a step.
  task automatic send_value(input logic [VAL_W-1:0] v);
    int gap;
    gap = pace_on ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      din_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din_if.valid <= 1'b1;
    din_if.value <= v;
    do @(posedge clk); while (!din_if.ready);
    sb.note_value(v);
  endtask

  // Stop sending and wait until every queued position has been checked.
  task automatic drain();
    din_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Width changes only with the block idle.
  task automatic write_field(input logic [sval7_pkg::CFG_W-1:0] w);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_field(w);
  endtask

  // Result side: random stall per position, then take and check it.
  initial begin : sink_side
    int          stall;
    seg_result_t got;
    dout_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = pace_on ? $urandom_range(0, 14) : 0;
      if (stall != 0) begin
        dout_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      dout_if.ready <= 1'b1;
      do @(posedge clk); while (!dout_if.valid);
      got.position = dout_if.position;
      got.segments = dout_if.segments;
      got.overflow = dout_if.overflow;
      got.last     = dout_if.last;
      sb.check_position(got);
    end
  end

  initial begin : source_side
    // Reset width is 4: cover fits, exact fits and overflow around it.
    logic [VAL_W-1:0] at_reset_width [$] = '{
      16'sd0, 16'sd1, -16'sd1, 16'sd9, -16'sd9, 16'sd10, 16'sd99, 16'sd100,
      16'sd999, -16'sd999, 16'sd1000, 16'sd9999, -16'sd1000, 16'sd10000,
      16'sd32767, 16'h8000, 16'h5555, 16'hAAAA
    };
    logic [VAL_W-1:0] at_full_width [$] = '{
      16'sd32767, 16'h8000, -16'sd1, 16'sd0, 16'sd12345
    };
    // Zero and fifteen hit the clamp on each side; 1 and 8 are the true limits.
    logic [sval7_pkg::CFG_W-1:0] phase_width [$] = '{
      4'd1, 4'd15, 4'd0, 4'd6, 4'd8, 4'd2, 4'd5, 4'd3
    };
    int ph, n;
    sb = new();
    pace_on = 1'b0;
    din_if.valid <= 1'b0;
    din_if.value <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (at_reset_width[n]) send_value(at_reset_width[n]);
    write_field(4'd8);
    foreach (at_full_width[n]) send_value(at_full_width[n]);

    // Random phases; idling is on in some phases and off in others, so some run flat out.
    foreach (phase_width[ph]) begin
      write_field(phase_width[ph]);
      pace_on = ph[0] || (ph == 2);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == PRESSURE_AT) drain();
        send_value(pick_value());
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.close_out();
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/sval7_pkg.sv
hw/rtl/sval7_if.sv
hw/rtl/sval7_bcd.sv
hw/rtl/signed_value_to_seven_segment.sv
sim/signed_value_to_seven_segment_tb.sv
